@@ sv/integer_to_ascii_formatter_macros.svh @@
// Assertion helpers used by the top-level formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ITAF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ITAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/itaf_pkg.sv @@
package itaf_pkg;

    localparam int VALUE_W    = 64;
    localparam int DEC_BITS   = 32;
    localparam int DEC_DIGITS = 10;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int HEX_DIGITS = VALUE_W / 4;
    localparam int CNT_W      = $clog2(HEX_DIGITS + 1);
    localparam int DAB_CNT_W  = $clog2(DEC_BITS);

    localparam logic [7:0] ASCII_NUL   = 8'h00;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2d;
    localparam logic [7:0] ASCII_LA    = 8'h61;
    localparam logic [7:0] ASCII_UA    = 8'h41;

    typedef enum logic [1:0] {
        KIND_SDEC = 2'd0,
        KIND_UDEC = 2'd1,
        KIND_LHEX = 2'd2,
        KIND_UHEX = 2'd3
    } itaf_kind_t;

    // Load request from the control sequencer to the character emitter.
    typedef struct packed {
        logic                 load;
        logic [VALUE_W-1:0]   digits;   // left aligned, one nibble per digit
        logic [CNT_W-1:0]     count;
        logic                 upper;
        logic                 negative;
        logic                 empty;
    } itaf_load_t;

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] base;
        if (nib < 4'd10) begin
            digit_char = ASCII_ZERO + {4'b0, nib};
        end else begin
            base       = upper ? ASCII_UA : ASCII_LA;
            digit_char = base + {4'b0, nib} - 8'd10;
        end
    endfunction

endpackage

@@ sv/itaf_dabble.sv @@
module itaf_dabble
    import itaf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DEC_BITS-1:0] bin_in,
    output logic                done,
    output logic [BCD_W-1:0]    bcd
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DAB_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEC_BITS-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     corr;

    // add-3 on every digit of 5 or more, digits independent
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                corr[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                corr[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = bin_in;
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next = {corr[BCD_W-2:0], bin_reg[DEC_BITS-1]};
            bin_next = {bin_reg[DEC_BITS-2:0], 1'b0};
            cnt_next = cnt_reg + DAB_CNT_W'(1);
            if (cnt_reg == DAB_CNT_W'(DEC_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

@@ sv/itaf_emit.sv @@
module itaf_emit
    import itaf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  itaf_load_t ld,
    output logic       busy,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [0:0] m_tuser
);

    typedef enum logic [1:0] {E_IDLE, E_SKIP, E_OUT} phase_t;

    phase_t               phase_reg, phase_next;
    logic [VALUE_W-1:0]   digits_reg, digits_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 upper_reg, upper_next;
    logic                 neg_reg, neg_next;
    logic                 empty_reg, empty_next;
    logic                 valid_reg, valid_next;
    logic [7:0]           data_reg, data_next;
    logic                 last_reg, last_next;
    logic                 eflag_reg, eflag_next;
    logic [3:0]           top_nib;
    logic                 out_free;

    assign top_nib  = digits_reg[VALUE_W-1 -: 4];
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        phase_next  = phase_reg;
        digits_next = digits_reg;
        cnt_next    = cnt_reg;
        upper_next  = upper_reg;
        neg_next    = neg_reg;
        empty_next  = empty_reg;
        valid_next  = valid_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        eflag_next  = eflag_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        unique case (phase_reg)
            E_IDLE: begin
                if (ld.load) begin
                    digits_next = ld.digits;
                    cnt_next    = ld.empty ? CNT_W'(1) : ld.count;
                    upper_next  = ld.upper;
                    neg_next    = ld.negative;
                    empty_next  = ld.empty;
                    phase_next  = ld.empty ? E_OUT : E_SKIP;
                end
            end
            E_SKIP: begin
                // drop leading zeros, one nibble a cycle, keep at least one digit
                if (cnt_reg > CNT_W'(1) && top_nib == 4'd0) begin
                    digits_next = {digits_reg[VALUE_W-5:0], 4'b0};
                    cnt_next    = cnt_reg - CNT_W'(1);
                end else begin
                    phase_next = E_OUT;
                end
            end
            E_OUT: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    if (neg_reg) begin
                        data_next  = ASCII_MINUS;
                        last_next  = 1'b0;
                        eflag_next = 1'b0;
                        neg_next   = 1'b0;
                    end else begin
                        data_next   = empty_reg ? ASCII_NUL : digit_char(top_nib, upper_reg);
                        last_next   = (cnt_reg == CNT_W'(1));
                        eflag_next  = empty_reg;
                        digits_next = {digits_reg[VALUE_W-5:0], 4'b0};
                        cnt_next    = cnt_reg - CNT_W'(1);
                        if (cnt_reg == CNT_W'(1)) begin
                            phase_next = E_IDLE;
                        end
                    end
                end
            end
            default: phase_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= E_IDLE;
            valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
        digits_reg <= digits_next;
        cnt_reg    <= cnt_next;
        upper_reg  <= upper_next;
        neg_reg    <= neg_next;
        empty_reg  <= empty_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
        eflag_reg  <= eflag_next;
    end

    assign busy       = (phase_reg != E_IDLE);
    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tlast    = last_reg;
    assign m_tuser[0] = eflag_reg;

endmodule

@@ sv/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter.
// Slave channel (s_*): one item per number. s_tdata carries the value (decimal: bits 31:0),
// s_tuser the kind (signed/unsigned dec, lower/upper hex) and the hex zero-suppress flag.
// Master channel (m_*): one item per character, most significant first, minus sign ahead of a
// negative signed decimal; m_tlast marks the final character, m_tuser flags a suppressed hex
// zero (a single NUL item).
// Timing: an item is taken when s_tvalid and s_tready are high; s_tready then stays low until
// the cycle after the last character has gone into the output register. Decimal items run the
// shared shift/add-3 unit and then load the emitter; the emitter strips leading zeros one
// nibble a cycle, then switches to output and sends one character a cycle while m_tready is
// high. Stripped nibbles plus characters come to 11 at most for decimal (minus sign included)
// and 16 for hex, which skips the converter and loads the emitter at once. The spacing from
// one item to the next is set by the 32-step converter loop and the nibble-a-cycle emitter.
// A stall on m_tready halts the emitter's output phase; the output register holds its item.
// The next number may be accepted while the last character of the previous one still waits.
// Reset (aresetn low, synchronous) empties the output register and returns to idle.
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter
    import itaf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,    // [63:0] value
    input  logic [2:0]         s_tuser,    // [1:0] kind, [2] suppress_zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,    // [7:0] character
    output logic               m_tlast,
    output logic [0:0]         m_tuser     // [0] empty_res
);

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

    state_t              state_reg, state_next;
    logic                neg_reg, neg_next;

    itaf_kind_t          kind;
    logic                suppress;
    logic [DEC_BITS-1:0] low;
    logic [DEC_BITS-1:0] mag;
    logic                is_neg;
    logic                accept;

    logic                dab_start;
    logic                dab_done;
    logic [BCD_W-1:0]    dab_bcd;
    logic                emit_busy;
    itaf_load_t          ld;

    assign kind     = itaf_kind_t'(s_tuser[1:0]);
    assign suppress = s_tuser[2];
    assign low      = s_tdata[DEC_BITS-1:0];
    assign is_neg   = (kind == KIND_SDEC) && low[DEC_BITS-1];
    // two's complement magnitude; the most negative value maps onto itself, which is right
    assign mag      = is_neg ? (~low + DEC_BITS'(1)) : low;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        neg_next    = neg_reg;
        dab_start   = 1'b0;
        ld          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (kind == KIND_SDEC || kind == KIND_UDEC) begin
                        dab_start  = 1'b1;
                        neg_next   = is_neg;
                        state_next = S_CONV;
                    end else begin
                        // hex: the nibbles are the digits already
                        ld.load    = 1'b1;
                        ld.digits  = s_tdata;
                        ld.count   = CNT_W'(HEX_DIGITS);
                        ld.upper   = (kind == KIND_UHEX);
                        ld.empty   = suppress && (s_tdata == '0);
                        state_next = S_EMIT;
                    end
                end
            end
            S_CONV: begin
                if (dab_done) begin
                    ld.load    = 1'b1;
                    ld.digits  = {dab_bcd, {(VALUE_W - BCD_W){1'b0}}};
                    ld.count   = CNT_W'(DEC_DIGITS);
                    ld.negative = neg_reg;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!emit_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            neg_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
        end
    end

    // shared shift/add-3 converter for the decimal kinds
    itaf_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dab_start),
        .bin_in  (mag),
        .done    (dab_done),
        .bcd     (dab_bcd)
    );

    // zero stripping, sign and character output register
    itaf_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld       (ld),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // a taken number keeps the input closed for at least the next cycle
    `ITAF_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "input open right after accept")
    // the converter only finishes while the sequencer waits for it
    `ITAF_ASSERT_NOW(a_done_in_conv, dab_done, state_reg == S_CONV, "converter done out of turn")
    // a suppressed zero is a lone NUL that closes the number
    `ITAF_ASSERT_NOW(a_empty_nul, m_tvalid && m_tuser[0], m_tlast && !(|m_tdata), "empty not NUL")

endmodule
